/* sv/ray_unit_square_intersect_core_assert.svh */
// Assertion macros for the unit square intersection core.
`ifndef RAY_UNIT_SQUARE_INTERSECT_CORE_ASSERT_SVH
`define RAY_UNIT_SQUARE_INTERSECT_CORE_ASSERT_SVH
`ifndef SYNTH
`define RUS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RUS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RUS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RUS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* sv/rusi_pkg.sv */
package rusi_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_X    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Z    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAR_LIM  = 2'd3;

  localparam logic [63:0] ROW_X_RESET   = 64'h0000_0000_0000_1000;
  localparam logic [63:0] ROW_Y_RESET   = 64'h0000_0000_1000_0000;
  localparam logic [63:0] ROW_Z_RESET   = 64'h0000_1000_0000_0000;
  localparam logic [15:0] PAR_LIM_RESET = 16'd1;

  localparam logic [31:0] T_POS_MAX = 32'h7fff_ffff;
  localparam logic [31:0] T_NEG_MAX = 32'h8000_0000;
  localparam logic [16:0] UV_ONE    = 17'h1_0000;
  localparam logic [16:0] UV_HALF   = 17'h0_8000;
  localparam logic [11:0] ROUND_Q28 = 12'h800;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] t_min;
    logic signed [31:0] t_max;
  } ray_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] t_hit;
    logic        [16:0] hit_u;
    logic        [16:0] hit_v;
    logic               back_face;
  } hit_t;

endpackage

/* sv/ray_unit_square_intersect_core.sv */
// Channel   | Ports                                  | Handshake
// ----------+----------------------------------------+---------------------------------
// ray in    | start_i, busy_o, ray_i                 | taken when start_i & !busy_o
// result    | result_valid_o, result_o               | one-cycle strobe, no back-pressure
// config    | cfg_we_i, cfg_idx_i, cfg_data_i        | written when cfg_we_i is high
//
// One item enters per cycle; busy_o stays low. Each result is registered through the
// transform stages, the restoring divider that resolves two quotient bits per stage,
// and the hit-point multiply stages.
// Reset clears all valid bits and loads the identity transform.
// Nothing stalls: the receiver must take each result in the cycle it is shown.
`include "ray_unit_square_intersect_core_assert.svh"

module ray_unit_square_intersect_core #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  rusi_pkg::ray_t                   ray_i,
  output logic                             result_valid_o,
  output rusi_pkg::hit_t                   result_o,
  input  logic                             cfg_we_i,
  input  logic [rusi_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rusi_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned SW  = 52;
  localparam int unsigned RW  = CW + 32;
  localparam int unsigned QW  = 32;
  localparam int unsigned BPS = 2;
  localparam int unsigned DS  = QW / BPS;
  localparam int unsigned HW  = CW - 15;
  localparam int unsigned PW  = CW + 18;
  localparam int unsigned UW  = PW + 2;
  localparam int unsigned LAT = DS + 6;

  localparam logic signed [SW-1:0] SAT_HI = (52'sd1 <<< (CW - 1)) - 52'sd1;
  localparam logic signed [SW-1:0] SAT_LO = -(52'sd1 <<< (CW - 1));

  typedef struct packed {
    logic signed [CW-1:0] ox;
    logic signed [CW-1:0] oy;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [31:0]   tmin;
    logic signed [31:0]   tmax;
    logic                 neg;
    logic                 back;
    logic                 miss;
    logic                 ovf;
    logic [RW-1:0]        rem;
    logic [CW-1:0]        den;
    logic [QW-1:0]        quo;
  } div_t;

  // Configuration registers.
  logic [63:0] row_q [3];
  logic [15:0] lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= rusi_pkg::ROW_X_RESET;
      row_q[1] <= rusi_pkg::ROW_Y_RESET;
      row_q[2] <= rusi_pkg::ROW_Z_RESET;
      lim_q    <= rusi_pkg::PAR_LIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rusi_pkg::REG_ROW_X:   row_q[0] <= cfg_data_i;
        rusi_pkg::REG_ROW_Y:   row_q[1] <= cfg_data_i;
        rusi_pkg::REG_ROW_Z:   row_q[2] <= cfg_data_i;
        rusi_pkg::REG_PAR_LIM: lim_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;
  logic in_acc;
  assign in_acc = start_i & ~busy_o & rst_ni;

  // Stage 1: coefficient products.
  logic signed [31:0] wo [3];
  logic signed [31:0] wd [3];
  assign wo[0] = ray_i.origin_x;
  assign wo[1] = ray_i.origin_y;
  assign wo[2] = ray_i.origin_z;
  assign wd[0] = ray_i.dir_x;
  assign wd[1] = ray_i.dir_y;
  assign wd[2] = ray_i.dir_z;

  logic signed [47:0] po_d [3][3];
  logic signed [47:0] po_q [3][3];
  logic signed [47:0] pd_d [3][3];
  logic signed [47:0] pd_q [3][3];
  logic signed [31:0] tmin1_q, tmax1_q;
  logic               v1_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int a = 0; a < 3; a++) begin
        po_d[r][a] = 48'($signed(row_q[r][16*a +: 16])) * 48'(wo[a]);
        pd_d[r][a] = 48'($signed(row_q[r][16*a +: 16])) * 48'(wd[a]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    po_q    <= po_d;
    pd_q    <= pd_d;
    tmin1_q <= ray_i.t_min;
    tmax1_q <= ray_i.t_max;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= in_acc;
    end
  end

  // Stage 2: row sums, rounding to Q16.16 and saturation.
  function automatic logic signed [CW-1:0] row_sum(
    input logic signed [47:0] p0,
    input logic signed [47:0] p1,
    input logic signed [47:0] p2,
    input logic signed [15:0] off
  );
    logic signed [SW-1:0] s;
    logic signed [SW-1:0] sh;
    logic signed [SW-1:0] r;
    s  = SW'(p0) + SW'(p1) + SW'(p2) + (SW'(off) <<< 20)
       + $signed(SW'(rusi_pkg::ROUND_Q28));
    sh = s >>> 12;
    if (sh > SAT_HI) begin
      r = SAT_HI;
    end else if (sh < SAT_LO) begin
      r = SAT_LO;
    end else begin
      r = sh;
    end
    return r[CW-1:0];
  endfunction

  logic signed [CW-1:0] oo_d [3];
  logic signed [CW-1:0] oo_q [3];
  logic signed [CW-1:0] od_d [3];
  logic signed [CW-1:0] od_q [3];
  logic signed [31:0]   tmin2_q, tmax2_q;
  logic                 v2_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      oo_d[r] = row_sum(po_q[r][0], po_q[r][1], po_q[r][2], $signed(row_q[r][63:48]));
      od_d[r] = row_sum(pd_q[r][0], pd_q[r][1], pd_q[r][2], 16'sd0);
    end
  end

  always_ff @(posedge clk_i) begin
    oo_q    <= oo_d;
    od_q    <= od_d;
    tmin2_q <= tmin1_q;
    tmax2_q <= tmax1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  // Stage 3: divider setup, parallel test and quotient overflow test.
  div_t           dv_q [DS+1];
  logic           dvv_q [DS+1];
  div_t           dv0_d;
  logic [CW-1:0]  mag_oz, mag_dz;

  always_comb begin
    mag_oz = oo_q[2][CW-1] ? CW'(-oo_q[2]) : CW'(oo_q[2]);
    mag_dz = od_q[2][CW-1] ? CW'(-od_q[2]) : CW'(od_q[2]);
    dv0_d.ox   = oo_q[0];
    dv0_d.oy   = oo_q[1];
    dv0_d.dx   = od_q[0];
    dv0_d.dy   = od_q[1];
    dv0_d.tmin = tmin2_q;
    dv0_d.tmax = tmax2_q;
    dv0_d.neg  = (oo_q[2] != '0) && (oo_q[2][CW-1] == od_q[2][CW-1]);
    dv0_d.back = ~od_q[2][CW-1] && (od_q[2] != '0);
    dv0_d.miss = (mag_dz == '0) || (mag_dz < CW'(lim_q));
    dv0_d.rem  = RW'(mag_oz) << 16;
    dv0_d.den  = mag_dz;
    dv0_d.ovf  = (RW'(mag_oz) << 16) >= (RW'(mag_dz) << QW);
    dv0_d.quo  = '0;
  end

  always_ff @(posedge clk_i) begin
    dv_q[0] <= dv0_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvv_q[0] <= 1'b0;
    end else begin
      dvv_q[0] <= v2_q;
    end
  end

  // Restoring divider, two quotient bits per stage, most significant first.
  for (genvar k = 1; k <= DS; k++) begin : g_div
    div_t dv_d;

    always_comb begin
      dv_d = dv_q[k-1];
      for (int j = 0; j < BPS; j++) begin
        if (dv_d.rem >= (RW'(dv_d.den) << (QW - (k - 1) * BPS - 1 - j))) begin
          dv_d.rem = dv_d.rem - (RW'(dv_d.den) << (QW - (k - 1) * BPS - 1 - j));
          dv_d.quo[QW-(k-1)*BPS-1-j] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      dv_q[k] <= dv_d;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dvv_q[k] <= 1'b0;
      end else begin
        dvv_q[k] <= dvv_q[k-1];
      end
    end
  end

  // Stage 4: signed, saturated t and range test.
  logic signed [31:0]   t_d, t4_q;
  logic [31:0]          mt4_q;
  logic [CW-1:0]        mbx4_q, mby4_q;
  logic                 sx4_q, sy4_q, back4_q, miss4_q, v4_q;
  logic signed [CW-1:0] ox4_q, oy4_q;
  div_t                 dvl;

  always_comb begin
    dvl = dv_q[DS];
    if (dvl.neg) begin
      t_d = (dvl.ovf || dvl.quo > rusi_pkg::T_NEG_MAX) ? $signed(rusi_pkg::T_NEG_MAX)
                                                      : $signed(-dvl.quo);
    end else begin
      t_d = (dvl.ovf || dvl.quo > rusi_pkg::T_POS_MAX) ? $signed(rusi_pkg::T_POS_MAX)
                                                      : $signed(dvl.quo);
    end
  end

  always_ff @(posedge clk_i) begin
    t4_q    <= t_d;
    mt4_q   <= t_d[31] ? 32'(-t_d) : 32'(t_d);
    mbx4_q  <= dvl.dx[CW-1] ? CW'(-dvl.dx) : CW'(dvl.dx);
    mby4_q  <= dvl.dy[CW-1] ? CW'(-dvl.dy) : CW'(dvl.dy);
    sx4_q   <= t_d[31] ^ dvl.dx[CW-1];
    sy4_q   <= t_d[31] ^ dvl.dy[CW-1];
    ox4_q   <= dvl.ox;
    oy4_q   <= dvl.oy;
    back4_q <= dvl.back;
    miss4_q <= dvl.miss || (t_d < dvl.tmin) || (t_d > dvl.tmax);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= dvv_q[DS];
    end
  end

  // Stage 5: partial products of t times the object direction.
  logic [32+HW-1:0]     phx5_q, phy5_q;
  logic [47:0]          plx5_q, ply5_q;
  logic signed [31:0]   t5_q;
  logic                 sx5_q, sy5_q, back5_q, miss5_q, v5_q;
  logic signed [CW-1:0] ox5_q, oy5_q;

  always_ff @(posedge clk_i) begin
    phx5_q  <= (32+HW)'(mt4_q) * (32+HW)'(HW'(mbx4_q >> 16));
    phy5_q  <= (32+HW)'(mt4_q) * (32+HW)'(HW'(mby4_q >> 16));
    plx5_q  <= 48'(mt4_q) * 48'(mbx4_q[15:0]);
    ply5_q  <= 48'(mt4_q) * 48'(mby4_q[15:0]);
    t5_q    <= t4_q;
    sx5_q   <= sx4_q;
    sy5_q   <= sy4_q;
    ox5_q   <= ox4_q;
    oy5_q   <= oy4_q;
    back5_q <= back4_q;
    miss5_q <= miss4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= v4_q;
    end
  end

  // Stage 6: hit point, surface test and result register.
  logic [PW-1:0]        px, py;
  logic signed [UW-1:0] u, v;
  logic                 hit;
  rusi_pkg::hit_t       res_d, res_q;
  logic                 rv_q;

  always_comb begin
    px  = PW'(phx5_q) + PW'(plx5_q >> 16);
    py  = PW'(phy5_q) + PW'(ply5_q >> 16);
    u   = UW'(ox5_q) + (sx5_q ? -$signed(UW'(px)) : $signed(UW'(px)))
        + $signed(UW'(rusi_pkg::UV_HALF));
    v   = UW'(oy5_q) + (sy5_q ? -$signed(UW'(py)) : $signed(UW'(py)))
        + $signed(UW'(rusi_pkg::UV_HALF));
    hit = ~miss5_q && ~u[UW-1] && ~v[UW-1]
        && (u <= $signed(UW'(rusi_pkg::UV_ONE))) && (v <= $signed(UW'(rusi_pkg::UV_ONE)));
    res_d           = '0;
    if (hit) begin
      res_d.hit       = 1'b1;
      res_d.t_hit     = t5_q;
      res_d.hit_u     = u[16:0];
      res_d.hit_v     = v[16:0];
      res_d.back_face = back5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else begin
      rv_q <= v5_q;
    end
  end

  assign result_o       = res_q;
  assign result_valid_o = rv_q;

  `RUS_ASSERT_NXT(a_enter, clk_i, rst_ni, in_acc, v1_q)
  `RUS_ASSERT_IMP(a_latency, clk_i, rst_ni, 1'b1, result_valid_o == $past(in_acc, LAT))
  `RUS_ASSERT_IMP(a_miss_zero, clk_i, rst_ni, result_valid_o && !result_o.hit,
    result_o.t_hit == '0 && result_o.hit_u == '0 && result_o.hit_v == '0 && !result_o.back_face)
  `RUS_ASSERT_IMP(a_uv_range, clk_i, rst_ni, result_valid_o && result_o.hit,
    result_o.hit_u <= rusi_pkg::UV_ONE && result_o.hit_v <= rusi_pkg::UV_ONE)

endmodule
